// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

    localparam int COMP_W = 16;
    localparam int FRAC_W = 8;
    localparam int PROD_W = 2 * COMP_W;
    localparam int DEN_W  = PROD_W;
    localparam int DVD_W  = PROD_W + FRAC_W;
    localparam int Q_W    = COMP_W + 1;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [COMP_W-1:0] a_real;
        logic signed [COMP_W-1:0] a_imag;
        logic signed [COMP_W-1:0] b_real;
        logic signed [COMP_W-1:0] b_imag;
    } t_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] res_real;
        logic signed [COMP_W-1:0] res_imag;
        logic                     div_zero;
        logic                     saturated;
    } t_out;

    // one divider lane: partial remainder, remaining dividend, quotient bits, overflow and sign flags
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [Q_W-1:0]   q;
        logic             ovf;
        logic             neg;
    } t_lane;

    // data that travels alongside the divider lanes
    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic [COMP_W-1:0] re;
        logic [COMP_W-1:0] im;
        logic              sat;
        logic [DEN_W-1:0]  den;
    } t_side;

endpackage

// ===== hw/rtl/cau_cell.sv =====
module cau_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cau_pkg::t_side i_side,
    input  cau_pkg::t_lane i_lane_re,
    input  cau_pkg::t_lane i_lane_im,
    output cau_pkg::t_side o_side,
    output cau_pkg::t_lane o_lane_re,
    output cau_pkg::t_lane o_lane_im
);
    import cau_pkg::*;

    t_side r_side;
    t_lane r_lane_re;
    t_lane r_lane_im;
    t_lane n_lane_re;
    t_lane n_lane_im;

    // one restoring division step
    function automatic t_lane div_step(input t_lane l, input logic [DEN_W-1:0] den);
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] diff;
        logic           ge;
        t_lane          r;
        rem2  = {l.rem, l.dvd[DVD_W-1]};
        diff  = rem2 - {1'b0, den};
        ge    = (rem2 >= {1'b0, den});
        r.rem = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        r.dvd = {l.dvd[DVD_W-2:0], 1'b0};
        r.q   = {l.q[Q_W-2:0], ge};
        r.ovf = l.ovf | l.q[Q_W-1];
        r.neg = l.neg;
        return r;
    endfunction

    always_comb begin
        n_lane_re = div_step(i_lane_re, i_side.den);
        n_lane_im = div_step(i_lane_im, i_side.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane_re <= n_lane_re;
            r_lane_im <= n_lane_im;
        end
    end

    assign o_side    = r_side;
    assign o_lane_re = r_lane_re;
    assign o_lane_im = r_lane_im;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// complex_arithmetic_unit
// input channel: i_valid / o_stall carry i_data (mode and two Q8.8 complex
// operands); a transfer happens on a clock edge with i_valid high and
// o_stall low
// output channel: o_valid / i_stall carry o_data (result, div_zero and
// saturated flags); a transfer happens with o_valid high and i_stall low
// modes: add, subtract, multiply (floor of the product), divide (quotient
// truncated toward zero, 0+0i with div_zero on a zero denominator)
// path: product and setup stages, a row of 40 divider cells (one quotient
// bit per cell) and an output stage; all modes take the same path so
// results stay in order
// throughput: one transfer per cycle in both directions while no stall holds the pipeline
// stall: while a result waits and i_stall is high, the whole pipeline holds
// and o_stall is raised; nothing is lost or repeated
// reset: i_rst_n synchronous active low empties the pipeline
module complex_arithmetic_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cau_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output cau_pkg::t_out  o_data
);
    import cau_pkg::*;

    logic adv;

    logic                     r_a_valid;
    logic [1:0]               r_a_mode;
    logic signed [PROD_W-1:0] r_pr_rr;
    logic signed [PROD_W-1:0] r_pr_ii;
    logic signed [PROD_W-1:0] r_pr_ri;
    logic signed [PROD_W-1:0] r_pr_ir;
    logic [PROD_W-1:0]        r_pr_bb_r;
    logic [PROD_W-1:0]        r_pr_bb_i;
    logic signed [COMP_W:0]   r_sum_re;
    logic signed [COMP_W:0]   r_sum_im;

    t_side r_b_side;
    t_lane r_b_lane_re;
    t_lane r_b_lane_im;
    t_side n_b_side;
    t_lane n_b_lane_re;
    t_lane n_b_lane_im;

    t_side side_c [DVD_W+1];
    t_lane lane_re_c [DVD_W+1];
    t_lane lane_im_c [DVD_W+1];

    t_out r_out;
    logic r_out_valid;
    t_out n_out;

    // {saturated, value}
    function automatic logic [COMP_W:0] clamp(input logic signed [PROD_W:0] v);
        logic over;
        over = !((&v[PROD_W:COMP_W-1]) || !(|v[PROD_W:COMP_W-1]));
        if (!over) begin
            return {1'b0, v[COMP_W-1:0]};
        end else if (v[PROD_W]) begin
            return {1'b1, 1'b1, {(COMP_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(COMP_W-1){1'b1}}};
        end
    endfunction

    // {saturated, value} from a quotient magnitude and its sign
    function automatic logic [COMP_W:0] fix_quot(input t_lane l);
        logic big;
        if (l.neg) begin
            big = l.ovf | l.q[Q_W-1] | (l.q[Q_W-2] & (|l.q[Q_W-3:0]));
            if (big) begin
                return {1'b1, 1'b1, {(COMP_W-1){1'b0}}};
            end
            return {1'b0, (~l.q[COMP_W-1:0]) + 1'b1};
        end
        big = l.ovf | l.q[Q_W-1] | l.q[Q_W-2];
        if (big) begin
            return {1'b1, 1'b0, {(COMP_W-1){1'b1}}};
        end
        return {1'b0, l.q[COMP_W-1:0]};
    endfunction

    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_mode  <= i_data.mode;
            r_pr_rr   <= i_data.a_real * i_data.b_real;
            r_pr_ii   <= i_data.a_imag * i_data.b_imag;
            r_pr_ri   <= i_data.a_real * i_data.b_imag;
            r_pr_ir   <= i_data.a_imag * i_data.b_real;
            r_pr_bb_r <= i_data.b_real * i_data.b_real;
            r_pr_bb_i <= i_data.b_imag * i_data.b_imag;
            if (i_data.mode == MODE_SUB) begin
                r_sum_re <= {i_data.a_real[COMP_W-1], i_data.a_real}
                          - {i_data.b_real[COMP_W-1], i_data.b_real};
                r_sum_im <= {i_data.a_imag[COMP_W-1], i_data.a_imag}
                          - {i_data.b_imag[COMP_W-1], i_data.b_imag};
            end else begin
                r_sum_re <= {i_data.a_real[COMP_W-1], i_data.a_real}
                          + {i_data.b_real[COMP_W-1], i_data.b_real};
                r_sum_im <= {i_data.a_imag[COMP_W-1], i_data.a_imag}
                          + {i_data.b_imag[COMP_W-1], i_data.b_imag};
            end
        end
    end

    // setup stage
    always_comb begin
        logic signed [PROD_W:0] mul_re;
        logic signed [PROD_W:0] mul_im;
        logic signed [PROD_W:0] num_re;
        logic signed [PROD_W:0] num_im;
        logic signed [PROD_W:0] mag_re;
        logic signed [PROD_W:0] mag_im;
        logic [COMP_W:0]        c_re;
        logic [COMP_W:0]        c_im;

        mul_re = $signed({r_pr_rr[PROD_W-1], r_pr_rr} - {r_pr_ii[PROD_W-1], r_pr_ii})
                 >>> FRAC_W;
        mul_im = $signed({r_pr_ri[PROD_W-1], r_pr_ri} + {r_pr_ir[PROD_W-1], r_pr_ir})
                 >>> FRAC_W;
        num_re = {r_pr_rr[PROD_W-1], r_pr_rr} + {r_pr_ii[PROD_W-1], r_pr_ii};
        num_im = {r_pr_ir[PROD_W-1], r_pr_ir} - {r_pr_ri[PROD_W-1], r_pr_ri};
        mag_re = num_re[PROD_W] ? -num_re : num_re;
        mag_im = num_im[PROD_W] ? -num_im : num_im;

        if (r_a_mode == MODE_MUL) begin
            c_re = clamp(mul_re);
            c_im = clamp(mul_im);
        end else begin
            c_re = clamp({{(PROD_W-COMP_W){r_sum_re[COMP_W]}}, r_sum_re});
            c_im = clamp({{(PROD_W-COMP_W){r_sum_im[COMP_W]}}, r_sum_im});
        end

        n_b_side.valid  = r_a_valid;
        n_b_side.is_div = (r_a_mode == MODE_DIV);
        n_b_side.den    = r_pr_bb_r + r_pr_bb_i;
        n_b_side.dz     = n_b_side.is_div && (n_b_side.den == '0);
        n_b_side.re     = c_re[COMP_W-1:0];
        n_b_side.im     = c_im[COMP_W-1:0];
        n_b_side.sat    = c_re[COMP_W] | c_im[COMP_W];

        n_b_lane_re.rem = '0;
        n_b_lane_re.dvd = {mag_re[PROD_W-1:0], {FRAC_W{1'b0}}};
        n_b_lane_re.q   = '0;
        n_b_lane_re.ovf = 1'b0;
        n_b_lane_re.neg = num_re[PROD_W];
        n_b_lane_im.rem = '0;
        n_b_lane_im.dvd = {mag_im[PROD_W-1:0], {FRAC_W{1'b0}}};
        n_b_lane_im.q   = '0;
        n_b_lane_im.ovf = 1'b0;
        n_b_lane_im.neg = num_im[PROD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side.valid <= 1'b0;
        end else if (adv) begin
            r_b_side <= n_b_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_lane_re <= n_b_lane_re;
            r_b_lane_im <= n_b_lane_im;
        end
    end

    // divider row
    assign side_c[0]    = r_b_side;
    assign lane_re_c[0] = r_b_lane_re;
    assign lane_im_c[0] = r_b_lane_im;

    for (genvar g = 0; g < DVD_W; g++) begin : g_cell
        cau_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (adv),
            .i_side    (side_c[g]),
            .i_lane_re (lane_re_c[g]),
            .i_lane_im (lane_im_c[g]),
            .o_side    (side_c[g+1]),
            .o_lane_re (lane_re_c[g+1]),
            .o_lane_im (lane_im_c[g+1])
        );
    end

    // output stage
    always_comb begin
        t_side           s;
        logic [COMP_W:0] f_re;
        logic [COMP_W:0] f_im;
        s    = side_c[DVD_W];
        f_re = fix_quot(lane_re_c[DVD_W]);
        f_im = fix_quot(lane_im_c[DVD_W]);
        if (!s.is_div) begin
            n_out.res_real  = s.re;
            n_out.res_imag  = s.im;
            n_out.div_zero  = 1'b0;
            n_out.saturated = s.sat;
        end else if (s.dz) begin
            n_out.res_real  = '0;
            n_out.res_imag  = '0;
            n_out.div_zero  = 1'b1;
            n_out.saturated = 1'b0;
        end else begin
            n_out.res_real  = f_re[COMP_W-1:0];
            n_out.res_imag  = f_im[COMP_W-1:0];
            n_out.div_zero  = 1'b0;
            n_out.saturated = f_re[COMP_W] | f_im[COMP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= side_c[DVD_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_dz_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.div_zero |->
            !o_data.saturated && o_data.res_real == '0 && o_data.res_imag == '0)
        else $error("division by zero result not cleared");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_a_valid && !r_b_side.valid)
        else $error("pipeline not empty after reset");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_a_valid) && $stable(r_b_side.valid))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    localparam int LATENCY     = 43;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SHOW_ERRORS = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    complex_arithmetic_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    t_out result_queue[$];
    int   mismatch_count;
    int   result_count;
    int   mode_count[4];
    int   div_zero_seen;
    int   sat_seen;
    int   idle_cycles;
    bit   send_gaps_on;
    bit   stall_on;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit out_of_range(longint v);
        return (v > 32767) || (v < -32768);
    endfunction

    function automatic logic [COMP_W-1:0] clamp_q(longint v);
        if (v > 32767) begin
            return 16'h7fff;
        end else if (v < -32768) begin
            return 16'h8000;
        end
        return v[COMP_W-1:0];
    endfunction

    function automatic t_out predict_result(t_in x);
        longint ar, ai, br, bi, re, im, den;
        t_out   r;
        ar = longint'(x.a_real);
        ai = longint'(x.a_imag);
        br = longint'(x.b_real);
        bi = longint'(x.b_imag);
        re = 0;
        im = 0;
        r = '0;
        case (t_mode'(x.mode))
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                re = (ar * br - ai * bi) >>> FRAC_W;
                im = (ar * bi + ai * br) >>> FRAC_W;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    // longint division truncates toward zero
                    re = ((ar * br + ai * bi) <<< FRAC_W) / den;
                    im = ((ai * br - ar * bi) <<< FRAC_W) / den;
                end
            end
        endcase
        r.saturated = out_of_range(re) || out_of_range(im);
        r.res_real  = clamp_q(re);
        r.res_imag  = clamp_q(im);
        return r;
    endfunction

    // input transfers: record what the block should produce
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            result_queue.push_back(predict_result(i_data));
            mode_count[i_data.mode]++;
        end
    end

    // output transfers: compare against the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (o_data.div_zero) div_zero_seen++;
            if (o_data.saturated) sat_seen++;
            if (result_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_ERRORS)
                    $display("unexpected result %h", o_data);
            end else begin
                want = result_queue.pop_front();
                if (o_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_ERRORS)
                        $display({"mismatch: exp re=%h im=%h dz=%b sat=%b, ",
                                  "got re=%h im=%h dz=%b sat=%b"},
                                 want.res_real, want.res_imag, want.div_zero, want.saturated,
                                 o_data.res_real, o_data.res_imag, o_data.div_zero,
                                 o_data.saturated);
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        int hold;
        int pick;
        if (!stall_on) begin
            i_stall <= 1'b0;
            hold = 0;
        end else if (hold > 0) begin
            hold--;
        end else begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                i_stall <= 1'b0;
                hold = $urandom_range(4);
            end else if (pick < 95) begin
                i_stall <= 1'b1;
                hold = $urandom_range(2);
            end else begin
                i_stall <= 1'b1;
                hold = $urandom_range(60, 20);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(input t_in x);
        int gap;
        if (send_gaps_on && $urandom_range(99) < 30) begin
            gap = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [COMP_W-1:0] pick_component();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in random_item(t_mode m);
        t_in x;
        x.mode   = m;
        x.a_real = pick_component();
        x.a_imag = pick_component();
        x.b_real = pick_component();
        x.b_imag = pick_component();
        return x;
    endfunction

    task automatic test_directed();
        send_item('{MODE_ADD, 16'h0100, 16'h0200, 16'h0080, 16'hff00});
        send_item('{MODE_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        send_item('{MODE_ADD, 16'h7fff, 16'h8000, 16'h0000, 16'h0000});
        send_item('{MODE_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
        send_item('{MODE_SUB, 16'h0300, 16'hfd00, 16'h0100, 16'h0100});
        send_item('{MODE_SUB, 16'h8000, 16'h0000, 16'h0001, 16'h0000});
        send_item('{MODE_MUL, 16'h0100, 16'h0000, 16'h0280, 16'hfe00});
        send_item('{MODE_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000});
        send_item('{MODE_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_item('{MODE_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff});
        send_item('{MODE_MUL, 16'h0180, 16'hff40, 16'hfe80, 16'h0033});
        send_item('{MODE_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000});
        send_item('{MODE_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000});
        send_item('{MODE_DIV, 16'h0200, 16'h0100, 16'h0100, 16'h0000});
        send_item('{MODE_DIV, 16'hfd00, 16'h0000, 16'h0300, 16'h0000});
        send_item('{MODE_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000});
        send_item('{MODE_DIV, 16'h8000, 16'h0000, 16'h0000, 16'h0001});
        send_item('{MODE_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_item('{MODE_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff});
        send_item('{MODE_DIV, 16'hffff, 16'h0000, 16'h0100, 16'h0000});
        send_item('{MODE_DIV, 16'h0100, 16'h0000, 16'hff00, 16'h0000});
        i_valid <= 1'b0;
    endtask

    task automatic test_random_modes(input int n);
        repeat (n) send_item(random_item(t_mode'($urandom_range(3))));
        i_valid <= 1'b0;
    endtask

    task automatic test_divide_range(input int n);
        t_in x;
        repeat (n) begin
            x = random_item(MODE_DIV);
            if ($urandom_range(3) != 0) begin
                x.b_real = 16'(signed'($urandom_range(2048)) - 1024);
                x.b_imag = 16'(signed'($urandom_range(2048)) - 1024);
            end
            send_item(x);
        end
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    initial begin
        mismatch_count = 0;
        result_count   = 0;
        div_zero_seen  = 0;
        sat_seen       = 0;
        idle_cycles    = 0;
        send_gaps_on   = 1'b0;
        stall_on       = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_gaps_on = 1'b1;
        stall_on     = 1'b1;
        test_random_modes(900);
        test_divide_range(500);
        send_gaps_on = 1'b0;
        stall_on     = 1'b0;
        test_random_modes(400);
        wait_drained();

        $display("%0d results checked: add %0d, sub %0d, mul %0d, div %0d",
                 result_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("%0d divide-by-zero and %0d saturated results, %0d mismatches",
                 div_zero_seen, sat_seen, mismatch_count);
        if (mismatch_count == 0 && result_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
